@@ rtl/angle_gyro_kalman_filter_assert.svh @@
// Assertion macros for the angle and gyro bias filter RTL, used by agk_ctrl.
`ifndef ANGLE_GYRO_KALMAN_FILTER_ASSERT_SVH
`define ANGLE_GYRO_KALMAN_FILTER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define AGK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define AGK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AGK_ASSERT_NOW(lbl, ante, cons, msg)
`define AGK_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/agk_pkg.sv @@
// Shared constants, types, micro-program and saturation helper of the filter.
package agk_pkg;

    // Data widths
    localparam int DW     = 48;
    localparam int MW     = 49;
    localparam int DT_W   = 33;
    localparam int QA_W   = 37;
    localparam int QB_W   = 37;
    localparam int MR_W   = 41;
    localparam int MEAS_W = 41;
    localparam int RATE_W = 44;
    localparam int CFG_W  = 41;
    localparam int IDX_W  = 2;
    localparam int STEP_W = 4;
    localparam int DIV_STEPS = 47;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_DT = 2'd0;
    localparam logic [IDX_W-1:0] REG_QA = 2'd1;
    localparam logic [IDX_W-1:0] REG_QB = 2'd2;
    localparam logic [IDX_W-1:0] REG_MR = 2'd3;

    // Reset values
    localparam logic [DT_W-1:0] DT_RST = 33'd4294967;
    localparam logic [QA_W-1:0] QA_RST = 37'd4294967;
    localparam logic [QB_W-1:0] QB_RST = 37'd21474836;
    localparam logic [MR_W-1:0] MR_RST = 41'd2147483648;
    localparam logic signed [DW-1:0] ONE_Q = 48'sh0001_0000_0000;

    // Saturation bounds
    localparam logic signed [DW-1:0] DMAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [DW-1:0] DMIN = 48'sh8000_0000_0000;
    localparam logic signed [51:0] SUM_MAX = 52'sd140737488355327;
    localparam logic signed [51:0] SUM_MIN = -52'sd140737488355328;

    // Step kinds
    localparam logic [2:0] K_MUL = 3'd0;
    localparam logic [2:0] K_DIV = 3'd1;
    localparam logic [2:0] K_ERR = 3'd2;
    localparam logic [2:0] K_DEN = 3'd3;
    localparam logic [2:0] K_OUT = 3'd4;

    // Multiplier operand selects
    localparam logic [3:0] MS_RATE = 4'd0;
    localparam logic [3:0] MS_D0   = 4'd1;
    localparam logic [3:0] MS_NBB  = 4'd2;
    localparam logic [3:0] MS_QB   = 4'd3;
    localparam logic [3:0] MS_K0T0 = 4'd4;
    localparam logic [3:0] MS_K0T1 = 4'd5;
    localparam logic [3:0] MS_K1T0 = 4'd6;
    localparam logic [3:0] MS_K1T1 = 4'd7;
    localparam logic [3:0] MS_K0E  = 4'd8;
    localparam logic [3:0] MS_K1E  = 4'd9;

    // Divider selects
    localparam logic [3:0] DIV_K0 = 4'd0;
    localparam logic [3:0] DIV_K1 = 4'd1;

    // Accumulate destinations
    localparam logic [2:0] AD_ANG  = 3'd0;
    localparam logic [2:0] AD_BIAS = 3'd1;
    localparam logic [2:0] AD_AA   = 3'd2;
    localparam logic [2:0] AD_AB   = 3'd3;
    localparam logic [2:0] AD_BA   = 3'd4;
    localparam logic [2:0] AD_BB   = 3'd5;
    localparam logic [2:0] AD_ABBA = 3'd6;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] sel;
        logic [2:0] dst;
        logic       sub;
    } prog_t;

    typedef struct packed {
        logic       capture;
        logic       mul_go;
        logic       div_go;
        logic       acc_go;
        logic       err_go;
        logic       den_go;
        logic       k_go;
        logic       out_go;
        logic [3:0] sel;
        logic [2:0] dst;
        logic       sub;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic den_pos;
        logic out_busy;
    } sts_t;

    // Micro-program: predict, gains, covariance and state update, result
    function automatic prog_t agk_prog(input logic [STEP_W-1:0] step);
        prog_t p;
        p = '{kind: K_OUT, sel: MS_RATE, dst: AD_ANG, sub: 1'b0};
        case (step)
            4'd0:  p = '{kind: K_MUL, sel: MS_RATE, dst: AD_ANG,  sub: 1'b0};
            4'd1:  p = '{kind: K_ERR, sel: MS_RATE, dst: AD_ANG,  sub: 1'b0};
            4'd2:  p = '{kind: K_MUL, sel: MS_D0,   dst: AD_AA,   sub: 1'b0};
            4'd3:  p = '{kind: K_MUL, sel: MS_NBB,  dst: AD_ABBA, sub: 1'b0};
            4'd4:  p = '{kind: K_MUL, sel: MS_QB,   dst: AD_BB,   sub: 1'b0};
            4'd5:  p = '{kind: K_DEN, sel: MS_RATE, dst: AD_ANG,  sub: 1'b0};
            4'd6:  p = '{kind: K_DIV, sel: DIV_K0,  dst: AD_ANG,  sub: 1'b0};
            4'd7:  p = '{kind: K_DIV, sel: DIV_K1,  dst: AD_ANG,  sub: 1'b0};
            4'd8:  p = '{kind: K_MUL, sel: MS_K0T0, dst: AD_AA,   sub: 1'b1};
            4'd9:  p = '{kind: K_MUL, sel: MS_K0T1, dst: AD_AB,   sub: 1'b1};
            4'd10: p = '{kind: K_MUL, sel: MS_K1T0, dst: AD_BA,   sub: 1'b1};
            4'd11: p = '{kind: K_MUL, sel: MS_K1T1, dst: AD_BB,   sub: 1'b1};
            4'd12: p = '{kind: K_MUL, sel: MS_K0E,  dst: AD_ANG,  sub: 1'b0};
            4'd13: p = '{kind: K_MUL, sel: MS_K1E,  dst: AD_BIAS, sub: 1'b0};
            default: p = '{kind: K_OUT, sel: MS_RATE, dst: AD_ANG, sub: 1'b0};
        endcase
        return p;
    endfunction

    // Clamp a wide sum to the signed 48-bit range
    function automatic logic signed [DW-1:0] sat48(input logic signed [51:0] x);
        logic signed [DW-1:0] r;
        if (x > SUM_MAX) begin
            r = DMAX;
        end else if (x < SUM_MIN) begin
            r = DMIN;
        end else begin
            r = x[DW-1:0];
        end
        return r;
    endfunction

    // Sign-extend a 48-bit value for sums
    function automatic logic signed [51:0] sx48(input logic signed [DW-1:0] v);
        return $signed({{4{v[DW-1]}}, v});
    endfunction

endpackage

@@ rtl/agk_mul.sv @@
// Multi-cycle signed Q16.32 multiplier, 49x17 partial product per cycle.
module agk_mul
    import agk_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [MW-1:0] a,
    input  logic signed [MW-1:0] b,
    output logic signed [DW-1:0] res,
    output logic                 done
);

    logic [MW-1:0]  ma_reg;
    logic [50:0]    mb_reg;
    logic [99:0]    acc_reg;
    logic           neg_reg;
    logic [1:0]     cnt_reg;
    logic           run_reg;
    logic           fin_reg;
    logic           done_reg;
    logic signed [DW-1:0] res_reg;
    logic [MW-1:0]  a_mag;
    logic [MW-1:0]  b_mag;
    logic [65:0]    pp;
    logic [67:0]    m;

    assign a_mag = a[MW-1] ? (~a + 49'd1) : a;
    assign b_mag = b[MW-1] ? (~b + 49'd1) : b;
    assign pp    = ma_reg * mb_reg[50:34];
    assign m     = acc_reg[99:32];

    // Sequence the three partial products and the final sign and clamp stage
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= 2'd0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd2) begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    // Accumulate most significant chunk first, then sign and clamp
    always_ff @(posedge clk) begin
        if (start) begin
            ma_reg  <= a_mag;
            mb_reg  <= {2'b00, b_mag};
            acc_reg <= '0;
            neg_reg <= a[MW-1] ^ b[MW-1];
        end else if (run_reg) begin
            acc_reg <= (acc_reg << 17) + {34'd0, pp};
            mb_reg  <= mb_reg << 17;
        end
        if (fin_reg) begin
            if (neg_reg) begin
                res_reg <= (m > 68'h8000_0000_0000) ? DMIN : (~m[DW-1:0] + 48'd1);
            end else begin
                res_reg <= (m > 68'h7FFF_FFFF_FFFF) ? DMAX : m[DW-1:0];
            end
        end
    end

    assign res  = res_reg;
    assign done = done_reg;

endmodule

@@ rtl/agk_div.sv @@
// Restoring divider for Q16.32 gains, one quotient bit per cycle.
module agk_div
    import agk_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] n,
    input  logic signed [DW-1:0] d,
    output logic signed [DW-1:0] res,
    output logic                 done
);

    logic [DW-1:0]  md_reg;
    logic [DW-1:0]  r_reg;
    logic [46:0]    sh_reg;
    logic [46:0]    q_reg;
    logic           neg_reg;
    logic [5:0]     cnt_reg;
    logic           run_reg;
    logic           fin_reg;
    logic           done_reg;
    logic signed [DW-1:0] res_reg;
    logic [DW-1:0]  mn;
    logic           ovf;
    logic [DW:0]    r2;
    logic           ge;
    logic [DW:0]    r_sub;

    assign mn    = n[DW-1] ? (~n + 48'd1) : n;
    assign ovf   = {15'd0, mn} >= {d, 15'd0};
    assign r2    = {r_reg, sh_reg[46]};
    assign ge    = r2 >= {1'b0, md_reg};
    assign r_sub = r2 - {1'b0, md_reg};

    // Count quotient bits; an overflowing quotient finishes at once
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            done_reg <= fin_reg || (start && ovf);
            fin_reg  <= 1'b0;
            if (start) begin
                run_reg <= !ovf;
                cnt_reg <= 6'd0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_STEPS - 1)) begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    // Shift in one dividend bit, subtract when it fits
    always_ff @(posedge clk) begin
        if (start) begin
            md_reg  <= d;
            r_reg   <= {15'd0, mn[DW-1:15]};
            sh_reg  <= {mn[14:0], 32'd0};
            q_reg   <= '0;
            neg_reg <= n[DW-1];
            if (ovf) begin
                res_reg <= n[DW-1] ? DMIN : DMAX;
            end
        end else if (run_reg) begin
            r_reg  <= ge ? r_sub[DW-1:0] : r2[DW-1:0];
            q_reg  <= {q_reg[45:0], ge};
            sh_reg <= sh_reg << 1;
        end
        if (fin_reg) begin
            res_reg <= neg_reg ? (~{1'b0, q_reg} + 48'd1) : {1'b0, q_reg};
        end
    end

    assign res  = res_reg;
    assign done = done_reg;

endmodule

@@ rtl/agk_datapath.sv @@
// Filter datapath: state, covariance, configuration, shared multiplier and divider.
module agk_datapath
    import agk_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic signed [MEAS_W-1:0] angle_meas,
    input  logic signed [RATE_W-1:0] gyro_rate,
    input  logic                     cfg_we,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]         cfg_wdata,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DW-1:0]     angle_est,
    output logic signed [DW-1:0]     rate_est
);

    logic [DT_W-1:0] dt_reg;
    logic [QA_W-1:0] qa_reg;
    logic [QB_W-1:0] qb_reg;
    logic [MR_W-1:0] mr_reg;
    logic signed [DW-1:0] ang_reg, bias_reg, caa_reg, cab_reg, cba_reg, cbb_reg;
    logic signed [MEAS_W-1:0] meas_reg;
    logic signed [RATE_W-1:0] rate_reg;
    logic signed [DW-1:0] err_reg, den_reg, t0_reg, t1_reg, k0_reg, k1_reg;
    logic signed [DW-1:0] angle_est_reg, rate_est_reg;
    logic out_valid_reg;

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [DW-1:0] mul_res, div_res;
    logic mul_done, div_done;
    logic signed [DW-1:0] div_n;
    logic signed [51:0] rate_x, meas_x;
    logic signed [DW-1:0] rate_corr, d0_part, d0;
    logic signed [MW-1:0] dt_x;

    assign rate_x    = $signed({{8{rate_reg[RATE_W-1]}}, rate_reg});
    assign meas_x    = $signed({{11{meas_reg[MEAS_W-1]}}, meas_reg});
    assign rate_corr = sat48(rate_x - sx48(bias_reg));
    assign d0_part   = sat48($signed({15'd0, qa_reg}) - sx48(cab_reg));
    assign d0        = sat48(sx48(d0_part) - sx48(cba_reg));
    assign dt_x      = $signed({16'd0, dt_reg});

    // Pick multiplier operands
    always_comb begin
        mul_a = {k0_reg[DW-1], k0_reg};
        mul_b = {t0_reg[DW-1], t0_reg};
        case (cmd.sel)
            MS_RATE: begin
                mul_a = {rate_corr[DW-1], rate_corr};
                mul_b = dt_x;
            end
            MS_D0: begin
                mul_a = {d0[DW-1], d0};
                mul_b = dt_x;
            end
            MS_NBB: begin
                mul_a = -{cbb_reg[DW-1], cbb_reg};
                mul_b = dt_x;
            end
            MS_QB: begin
                mul_a = $signed({12'd0, qb_reg});
                mul_b = dt_x;
            end
            MS_K0T0: begin
                mul_a = {k0_reg[DW-1], k0_reg};
                mul_b = {t0_reg[DW-1], t0_reg};
            end
            MS_K0T1: begin
                mul_a = {k0_reg[DW-1], k0_reg};
                mul_b = {t1_reg[DW-1], t1_reg};
            end
            MS_K1T0: begin
                mul_a = {k1_reg[DW-1], k1_reg};
                mul_b = {t0_reg[DW-1], t0_reg};
            end
            MS_K1T1: begin
                mul_a = {k1_reg[DW-1], k1_reg};
                mul_b = {t1_reg[DW-1], t1_reg};
            end
            MS_K0E: begin
                mul_a = {k0_reg[DW-1], k0_reg};
                mul_b = {err_reg[DW-1], err_reg};
            end
            MS_K1E: begin
                mul_a = {k1_reg[DW-1], k1_reg};
                mul_b = {err_reg[DW-1], err_reg};
            end
            default: begin
                mul_a = {k0_reg[DW-1], k0_reg};
                mul_b = {t0_reg[DW-1], t0_reg};
            end
        endcase
    end

    assign div_n = (cmd.sel == DIV_K1) ? cba_reg : t0_reg;

    agk_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .res   (mul_res),
        .done  (mul_done)
    );

    agk_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_go),
        .n     (div_n),
        .d     (den_reg),
        .res   (div_res),
        .done  (div_done)
    );

    // Add or subtract the product into a state word
    function automatic logic signed [DW-1:0] accum(input logic signed [DW-1:0] x,
                                                   input logic signed [DW-1:0] p,
                                                   input logic sub);
        return sub ? sat48(sx48(x) - sx48(p)) : sat48(sx48(x) + sx48(p));
    endfunction

    // Hold filter state and configuration
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            dt_reg        <= DT_RST;
            qa_reg        <= QA_RST;
            qb_reg        <= QB_RST;
            mr_reg        <= MR_RST;
            ang_reg       <= '0;
            bias_reg      <= '0;
            caa_reg       <= ONE_Q;
            cab_reg       <= '0;
            cba_reg       <= '0;
            cbb_reg       <= ONE_Q;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_DT:  dt_reg <= cfg_wdata[DT_W-1:0];
                    REG_QA:  qa_reg <= cfg_wdata[QA_W-1:0];
                    REG_QB:  qb_reg <= cfg_wdata[QB_W-1:0];
                    REG_MR:  mr_reg <= cfg_wdata[MR_W-1:0];
                    default: dt_reg <= dt_reg;
                endcase
            end
            if (cmd.acc_go) begin
                case (cmd.dst)
                    AD_ANG:  ang_reg  <= accum(ang_reg, mul_res, cmd.sub);
                    AD_BIAS: bias_reg <= accum(bias_reg, mul_res, cmd.sub);
                    AD_AA:   caa_reg  <= accum(caa_reg, mul_res, cmd.sub);
                    AD_AB:   cab_reg  <= accum(cab_reg, mul_res, cmd.sub);
                    AD_BA:   cba_reg  <= accum(cba_reg, mul_res, cmd.sub);
                    AD_BB:   cbb_reg  <= accum(cbb_reg, mul_res, cmd.sub);
                    AD_ABBA: begin
                        cab_reg <= accum(cab_reg, mul_res, cmd.sub);
                        cba_reg <= accum(cba_reg, mul_res, cmd.sub);
                    end
                    default: ang_reg <= ang_reg;
                endcase
            end
            if (cmd.out_go) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the input word, innovation, denominator, gains and result word
    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            meas_reg <= angle_meas;
            rate_reg <= gyro_rate;
        end
        if (cmd.err_go) begin
            err_reg <= sat48(meas_x - sx48(ang_reg));
        end
        if (cmd.den_go) begin
            den_reg <= sat48($signed({11'd0, mr_reg}) + sx48(caa_reg));
            t0_reg  <= caa_reg;
            t1_reg  <= cab_reg;
            k0_reg  <= '0;
            k1_reg  <= '0;
        end
        if (cmd.k_go) begin
            if (cmd.sel == DIV_K1) begin
                k1_reg <= div_res;
            end else begin
                k0_reg <= div_res;
            end
        end
        if (cmd.out_go) begin
            angle_est_reg <= ang_reg;
            rate_est_reg  <= rate_corr;
        end
    end

    assign sts.mul_done = mul_done;
    assign sts.div_done = div_done;
    assign sts.den_pos  = !den_reg[DW-1] && (den_reg != '0);
    assign sts.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign angle_est = angle_est_reg;
    assign rate_est  = rate_est_reg;

endmodule

@@ rtl/agk_ctrl.sv @@
// Filter sequencer: steps the micro-program and issues datapath commands.
`include "angle_gyro_kalman_filter_assert.svh"
module agk_ctrl
    import agk_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    prog_t             prog;

    assign prog     = agk_prog(step_reg);
    assign in_ready = (state_reg == S_IDLE);

    // Decode the current step into commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    step_next   = '0;
                    state_next  = S_ISSUE;
                end
            end
            S_ISSUE: begin
                case (prog.kind)
                    K_MUL: begin
                        cmd.mul_go = 1'b1;
                        cmd.sel    = prog.sel;
                        state_next = S_WAIT;
                    end
                    K_DIV: begin
                        cmd.sel = prog.sel;
                        if (sts.den_pos) begin
                            cmd.div_go = 1'b1;
                            state_next = S_WAIT;
                        end else begin
                            step_next = step_reg + 4'd1;
                        end
                    end
                    K_ERR: begin
                        cmd.err_go = 1'b1;
                        step_next  = step_reg + 4'd1;
                    end
                    K_DEN: begin
                        cmd.den_go = 1'b1;
                        step_next  = step_reg + 4'd1;
                    end
                    K_OUT: begin
                        if (!sts.out_busy) begin
                            cmd.out_go = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_WAIT: begin
                cmd.sel = prog.sel;
                if (prog.kind == K_MUL) begin
                    if (sts.mul_done) begin
                        cmd.acc_go = 1'b1;
                        cmd.dst    = prog.dst;
                        cmd.sub    = prog.sub;
                        step_next  = step_reg + 4'd1;
                        state_next = S_ISSUE;
                    end
                end else if (sts.div_done) begin
                    cmd.k_go   = 1'b1;
                    step_next  = step_reg + 4'd1;
                    state_next = S_ISSUE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Advance state and step
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    `AGK_ASSERT_NEXT(a_capture_starts, cmd.capture, (state_reg == S_ISSUE) && (step_reg == '0), "capture did not start the program")
    `AGK_ASSERT_NOW(a_acc_after_mul, cmd.acc_go, sts.mul_done, "accumulate without product")
    `AGK_ASSERT_NOW(a_div_needs_den, cmd.div_go, sts.den_pos, "divide with non-positive denominator")
    `AGK_ASSERT_NOW(a_out_slot_free, cmd.out_go, !sts.out_busy, "result word overwritten while stalled")

endmodule

@@ rtl/angle_gyro_kalman_filter.sv @@
// Top level of the two-state angle and gyro bias Kalman filter.
// Usage:
//   Input channel in_valid/in_ready carries one word: angle_meas (Q9.32
//   degrees) and gyro_rate (Q12.32 deg/s). Output channel out_valid/out_ready
//   returns one word per input: angle_est and rate_est, both saturated Q16.32.
//   Configuration: pulse cfg_we with cfg_index (0 dt, 1 Q_angle, 2 Q_gyro,
//   3 R_angle) and cfg_wdata while the filter is idle.
// Processing:
//   One word is processed at a time through a shared 49x17 multiplier (10
//   products) and a one-bit-per-cycle divider (2 gains; a gain that
//   saturates skips the bit loop). in_ready returns when the result is
//   loaded into the output register, so a new word is accepted only after
//   the previous result is loaded. With a non-positive gain denominator
//   the divisions are skipped and both gains stay zero.
// Reset and stall:
//   rst_n clears angle, bias and covariance (diagonal to one) and loads the
//   default configuration. A stalled receiver holds the result word in the
//   output register; the next input word is still accepted and processed,
//   and its result waits until the held word is taken.
module angle_gyro_kalman_filter
    import agk_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [MEAS_W-1:0] angle_meas,
    input  logic signed [RATE_W-1:0] gyro_rate,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DW-1:0]     angle_est,
    output logic signed [DW-1:0]     rate_est,
    input  logic                     cfg_we,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]         cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    agk_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .angle_meas (angle_meas),
        .gyro_rate  (gyro_rate),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .angle_est  (angle_est),
        .rate_est   (rate_est)
    );

    agk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

endmodule

@@ sim/angle_gyro_kalman_filter_tb.sv @@
// Self-checking testbench for the angle and gyro bias Kalman filter.
module angle_gyro_kalman_filter_tb
    import agk_pkg::*;
();

    localparam longint SAT_HI = 64'sd140737488355327;
    localparam longint SAT_LO = -64'sd140737488355328;
    localparam longint MEAS_HI = 64'sd773094113280;
    localparam longint RATE_HI = 64'sd8589934592000;
    localparam longint CYCLE_LIMIT = 2000000;

    // Filter predictor and queue of expected result words
    class kalman_scoreboard;
        longint angle, bias, p_aa, p_ab, p_ba, p_bb;
        longint dt, q_angle, q_bias, r_meas;
        longint exp_angle[$];
        longint exp_rate[$];
        int errors;

        function new();
            angle = 0; bias = 0; p_aa = 64'sd4294967296; p_ab = 0; p_ba = 0;
            p_bb = 64'sd4294967296;
            dt = 4294967; q_angle = 4294967; q_bias = 21474836;
            r_meas = 64'sd2147483648;
            errors = 0;
        endfunction

        function longint clamp(longint x);
            if (x > SAT_HI) return SAT_HI;
            if (x < SAT_LO) return SAT_LO;
            return x;
        endfunction

        function longint signed_mag(longint unsigned m, bit neg);
            if (m > (64'd1 << 48)) m = 64'd1 << 48;
            return clamp(neg ? -longint'(m) : longint'(m));
        endfunction

        function longint fmul(longint a, longint b);
            longint unsigned ma, mb, ah, al, bh, bl, m;
            ma = a < 0 ? -a : a;
            mb = b < 0 ? -b : b;
            ah = ma >> 32; al = ma & 64'hFFFF_FFFF;
            bh = mb >> 32; bl = mb & 64'hFFFF_FFFF;
            if (ah * bh >= (64'd1 << 15))
                m = 64'd1 << 48;
            else
                m = ((ah * bh) << 32) + ah * bl + al * bh + ((al * bl) >> 32);
            return signed_mag(m, (a < 0) != (b < 0));
        endfunction

        function longint fdiv(longint n, longint d);
            longint unsigned mn, md, qi, r, frac, m;
            mn = n < 0 ? -n : n;
            md = d;
            qi = mn / md;
            r = mn % md;
            frac = 0;
            if (qi >= (64'd1 << 15)) begin
                m = 64'd1 << 48;
            end else begin
                for (int i = 0; i < 32; i++) begin
                    r = r << 1;
                    frac = frac << 1;
                    if (r >= md) begin
                        r = r - md;
                        frac = frac | 1;
                    end
                end
                m = (qi << 32) | frac;
            end
            return signed_mag(m, n < 0);
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_DT: dt = longint'(val[DT_W-1:0]);
                REG_QA: q_angle = longint'(val[QA_W-1:0]);
                REG_QB: q_bias = longint'(val[QB_W-1:0]);
                REG_MR: r_meas = longint'(val[MR_W-1:0]);
                default: ;
            endcase
        endfunction

        // Advance the filter by one word and queue its result
        function void note_input(logic signed [MEAS_W-1:0] am, logic signed [RATE_W-1:0] gr);
            longint meas, rate, innov, d0, nbb, den, k0, k1, t0, t1;
            meas = am;
            rate = gr;
            k0 = 0;
            k1 = 0;
            angle = clamp(angle + fmul(clamp(rate - bias), dt));
            innov = clamp(meas - angle);
            d0 = clamp(clamp(q_angle - p_ab) - p_ba);
            nbb = -p_bb;
            p_aa = clamp(p_aa + fmul(d0, dt));
            p_ab = clamp(p_ab + fmul(nbb, dt));
            p_ba = clamp(p_ba + fmul(nbb, dt));
            p_bb = clamp(p_bb + fmul(q_bias, dt));
            den = clamp(r_meas + p_aa);
            if (den > 0) begin
                k0 = fdiv(p_aa, den);
                k1 = fdiv(p_ba, den);
            end
            t0 = p_aa;
            t1 = p_ab;
            p_aa = clamp(p_aa - fmul(k0, t0));
            p_ab = clamp(p_ab - fmul(k0, t1));
            p_ba = clamp(p_ba - fmul(k1, t0));
            p_bb = clamp(p_bb - fmul(k1, t1));
            angle = clamp(angle + fmul(k0, innov));
            bias = clamp(bias + fmul(k1, innov));
            exp_angle.push_back(angle);
            exp_rate.push_back(clamp(rate - bias));
        endfunction

        function void check_result(logic signed [DW-1:0] a, logic signed [DW-1:0] r);
            longint ea, er;
            if (exp_angle.size() == 0) begin
                $display("%0t: unexpected result word angle %0d rate %0d", $time, a, r);
                errors++;
                return;
            end
            ea = exp_angle.pop_front();
            er = exp_rate.pop_front();
            if (longint'(a) != ea) begin
                $display("%0t: angle_est expected %0d actual %0d", $time, ea, a);
                errors++;
            end
            if (longint'(r) != er) begin
                $display("%0t: rate_est expected %0d actual %0d", $time, er, r);
                errors++;
            end
        endfunction

        function int pending();
            return exp_angle.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [MEAS_W-1:0] angle_meas;
    logic signed [RATE_W-1:0] gyro_rate;
    logic out_valid;
    logic out_ready;
    logic signed [DW-1:0] angle_est;
    logic signed [DW-1:0] rate_est;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    kalman_scoreboard sb;
    longint cycles;
    bit hold_req;

    angle_gyro_kalman_filter dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .angle_meas(angle_meas), .gyro_rate(gyro_rate),
        .out_valid(out_valid), .out_ready(out_ready),
        .angle_est(angle_est), .rate_est(rate_est),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watch both channels and the cycle budget
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("angle_gyro_kalman_filter_tb: errors");
            $finish;
        end
        if (rst_n && in_valid && in_ready)
            sb.note_input(angle_meas, gyro_rate);
        if (rst_n && out_valid && out_ready)
            sb.check_result(angle_est, rate_est);
    end

    // Take result words with random stalls and one long hold-off
    initial begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready = 1'b0;
                repeat (1500) @(negedge clk);
            end
            gap = $urandom_range(0, 11);
            if (gap > 0) begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic longint rand_span(longint hi);
        longint unsigned u;
        u = {$urandom, $urandom};
        return longint'(u % longint'(2 * hi + 1)) - hi;
    endfunction

    // Offer one word, holding it until accepted
    task automatic send_word(longint am, longint gr);
        int gap;
        gap = $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        angle_meas = am[MEAS_W-1:0];
        gyro_rate = gr[RATE_W-1:0];
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_random(int count);
        longint am, gr;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 3))
                0: begin
                    am = rand_span(MEAS_HI);
                    gr = rand_span(RATE_HI);
                end
                1: begin
                    am = rand_span(64'sd90 << 32);
                    gr = rand_span(64'sd500 << 32);
                end
                default: begin
                    // Slow tilt with a steady gyro offset
                    am = rand_span(64'sd30 << 32);
                    gr = rand_span(64'sd20 << 32) + (64'sd3 << 32);
                end
            endcase
            send_word(am, gr);
        end
    endtask

    // Drain, then write registers while idle
    task automatic write_cfg(logic [DT_W-1:0] dtv, logic [QA_W-1:0] qav,
                             logic [QB_W-1:0] qbv, logic [MR_W-1:0] mrv);
        in_valid = 1'b0;
        while (sb.pending() > 0) @(negedge clk);
        repeat (200) @(negedge clk);
        for (int i = 0; i < 4; i++) begin
            cfg_we = 1'b1;
            cfg_index = i[IDX_W-1:0];
            case (i)
                0: cfg_wdata = CFG_W'(dtv);
                1: cfg_wdata = CFG_W'(qav);
                2: cfg_wdata = CFG_W'(qbv);
                default: cfg_wdata = CFG_W'(mrv);
            endcase
            sb.write_reg(cfg_index, cfg_wdata);
            @(negedge clk);
        end
        cfg_we = 1'b0;
    endtask

    initial begin
        sb = new();
        cycles = 0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        angle_meas = '0;
        gyro_rate = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: field extremes under the reset settings
        send_word(0, 0);
        send_word(MEAS_HI, 0);
        send_word(-MEAS_HI, 0);
        send_word(0, RATE_HI);
        send_word(0, -RATE_HI);
        send_word(MEAS_HI, RATE_HI);
        send_word(-MEAS_HI, -RATE_HI);
        send_word(1, -1);
        send_word(-1, 1);
        send_word(64'sd45 << 32, 64'sd10 << 32);
        send_word(-(64'sd45 << 32), -(64'sd10 << 32));
        send_word(64'sh1_5555_5555, 64'sh2_AAAA_AAAA);

        // Directed: zero noise settings, so the gain denominator is the angle variance alone
        write_cfg(33'd4294967, 37'd0, 37'd0, 41'd0);
        send_word(MEAS_HI, RATE_HI);
        send_word(-MEAS_HI, -RATE_HI);
        send_word(64'sd10 << 32, 64'sd1 << 32);
        send_word(0, 0);

        // Directed: largest settings then smallest
        write_cfg({DT_W{1'b1}}, {QA_W{1'b1}}, {QB_W{1'b1}}, {MR_W{1'b1}});
        send_word(MEAS_HI, -RATE_HI);
        send_word(-MEAS_HI, RATE_HI);
        send_word(0, 0);
        write_cfg(33'd1, 37'd0, 37'd0, 41'd1);
        send_word(MEAS_HI, RATE_HI);
        send_word(-MEAS_HI, 0);

        // Random: reset-like settings, with one long receiver hold-off
        write_cfg(33'd4294967, 37'd4294967, 37'd21474836, 41'd2147483648);
        send_random(60);
        hold_req = 1'b1;
        send_random(60);

        write_cfg(33'd4294967296, 37'd68719476736, 37'd68719476736, 41'd1099511627776);
        send_random(110);

        write_cfg(33'd1, 37'd0, 37'd0, 41'd1);
        send_random(100);

        write_cfg(33'd42949673, 37'd429496729, 37'd0, 41'd0);
        send_random(80);

        for (int ph = 0; ph < 3; ph++) begin
            write_cfg({1'($urandom_range(0, 1)), $urandom},
                      {5'($urandom_range(0, 31)), $urandom},
                      {5'($urandom_range(0, 31)), $urandom},
                      {9'($urandom_range(0, 511)), $urandom});
            send_random(90);
        end
        in_valid = 1'b0;

        // Drain and let the block settle
        while (sb.pending() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("angle_gyro_kalman_filter_tb: clean");
        else
            $display("angle_gyro_kalman_filter_tb: errors");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl
rtl/agk_pkg.sv
rtl/agk_mul.sv
rtl/agk_div.sv
rtl/agk_datapath.sv
rtl/agk_ctrl.sv
rtl/angle_gyro_kalman_filter.sv
sim/angle_gyro_kalman_filter_tb.sv
